// ===== rtl/core/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, color codes and the pair-to-color map for the artifact
// color line expander.
// ----------------------------------------------------------------------------
package ale_pkg;

  typedef logic [2:0] pix_t;
  typedef pix_t [7:0] pix_row_t;  // index 0 is the leftmost pixel, lowest bits

  localparam pix_t COL_BLUE   = 3'd1;
  localparam pix_t COL_ORANGE = 3'd2;
  localparam pix_t COL_WHITE  = 3'd3;
  localparam pix_t COL_BLACK  = 3'd4;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAIRS  = 4;
  localparam int unsigned PIX_W  = 3;
  localparam int unsigned ROW_W  = 2 * PAIRS * PIX_W;

  typedef struct packed {
    logic has_next;
    pix_t next_col;
    pix_t prior_right;
    logic prior_valid;
  } fix_ctx_t;

  function automatic pix_t pair_color(input logic [1:0] code);
    pix_t c;
    unique case (code)
      2'b00: c = COL_BLACK;
      2'b01: c = COL_BLUE;
      2'b10: c = COL_ORANGE;
      default: c = COL_WHITE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ale_fix.sv =====
// ----------------------------------------------------------------------------
// ale_fix
// Expands one source byte to eight pixels and applies the artifact
// correction pair by pair, left to right.
// ----------------------------------------------------------------------------
module ale_fix import ale_pkg::*; (
  input  logic [BYTE_W-1:0] src,
  input  fix_ctx_t          ctx,
  output pix_row_t          pix,
  output pix_t              right_out
);

  always_comb begin
    pix_t cols [PAIRS];
    pix_t prev;
    logic pvalid;
    logic nx;
    pix_t nc;
    pix_t lft;
    pix_t rgt;
    for (int i = 0; i < PAIRS; i++) begin
      cols[i] = pair_color(src[BYTE_W-1-2*i -: 2]);
    end
    prev   = ctx.prior_right;
    pvalid = ctx.prior_valid;
    pix    = '0;
    for (int i = 0; i < PAIRS; i++) begin
      nx  = (i < PAIRS - 1) ? 1'b1 : ctx.has_next;
      nc  = (i < PAIRS - 1) ? cols[(i + 1) % PAIRS] : ctx.next_col;
      lft = cols[i];
      rgt = cols[i];
      if (cols[i] == COL_BLUE && nx) begin
        if (nc == COL_ORANGE || nc == COL_WHITE) begin
          lft = COL_BLACK;
          rgt = COL_WHITE;
        end
      end else if (cols[i] == COL_ORANGE && pvalid) begin
        if (prev == COL_BLUE || prev == COL_WHITE) begin
          lft = COL_WHITE;
          rgt = COL_BLACK;
        end
      end
      pix[2*i]   = lft;
      pix[2*i+1] = rgt;
      prev       = rgt;
      pvalid     = 1'b1;
    end
    right_out = prev;
  end

endmodule

// ===== rtl/core/artifact_color_line_expander.sv =====
// ----------------------------------------------------------------------------
// artifact_color_line_expander
// Expands a 1 bpp scanline, one byte per beat, to 3-bit artifact colors,
// holding one byte back as lookahead for the correction rule.
//
//   channel  dir  tdata (low bit up)                      tlast
//   s_       in   in_byte[7:0]                            row_end
//   m_       out  pix_a..pix_h, 3 bits each, [23:0]       line_done
//
// One input beat per cycle is taken while s_tready is high. A byte with
// row_end while another byte is held yields two result beats and stays in
// the input register until both are out; every other byte yields at most one.
// Data path: input register, correction logic, output register.
// Reset clears the held byte, the row state and both valid flags.
// A stalled output register stalls the input register once its byte needs
// an output beat, which then stalls s_tready.
// ----------------------------------------------------------------------------
module artifact_color_line_expander import ale_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,   // in_byte
  input  logic              s_tlast,   // row_end
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [ROW_W-1:0]  m_tdata,   // pix_a, pix_b, ... pix_h
  output logic              m_tlast    // line_done
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_end;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  pix_t              prior_right;
  logic              prior_valid;

  logic              slot_free;
  logic              emit;
  logic              retire;
  logic              emit_last;
  fix_ctx_t          ctx;
  pix_row_t          fix_pix;
  pix_t              fix_right;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = s1_valid && (held_valid || s1_end) && slot_free;
  assign emit_last = !held_valid;
  assign retire    = s1_valid && (held_valid ? (emit && !s1_end) : (!s1_end || emit));
  assign s_tready  = !s1_valid || retire;

  assign ctx.has_next    = held_valid;
  assign ctx.next_col    = pair_color(s1_byte[BYTE_W-1 -: 2]);
  assign ctx.prior_right = prior_right;
  assign ctx.prior_valid = prior_valid;

  ale_fix u_fix (
    .src       (held_valid ? held_byte : s1_byte),
    .ctx       (ctx),
    .pix       (fix_pix),
    .right_out (fix_right)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
      s1_end  <= s_tlast;
    end
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_byte   <= '0;
      prior_right <= COL_BLACK;
      prior_valid <= 1'b0;
    end else begin
      if (emit) begin
        if (emit_last) begin
          prior_right <= COL_BLACK;
          prior_valid <= 1'b0;
        end else begin
          prior_right <= fix_right;
          prior_valid <= 1'b1;
        end
      end
      if (retire && !s1_end) begin
        held_byte  <= s1_byte;
        held_valid <= 1'b1;
      end else if (emit && held_valid) begin
        held_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= fix_pix;
      m_tlast <= emit_last;
    end
  end

  logic codes_ok;
  always_comb begin
    codes_ok = 1'b1;
    for (int i = 0; i < 2 * PAIRS; i++) begin
      if (m_tdata[PIX_W*i +: PIX_W] == 3'd0 || m_tdata[PIX_W*i +: PIX_W] > COL_BLACK) begin
        codes_ok = 1'b0;
      end
    end
  end

  a_row_reset: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> !prior_valid && prior_right == COL_BLACK)
    else $error("row state not cleared after last beat of line");

  a_flush_two: assert property (@(posedge clk) disable iff (rst)
    emit && held_valid && s1_end |=> s1_valid && !held_valid)
    else $error("row end with held byte did not keep its second beat");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> codes_ok)
    else $error("output pixel code out of range");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |-> s1_end && !held_valid)
    else $error("last beat emitted while a byte is held");

endmodule
